FILE: sv/jac_pkg.sv
// Shared types and constants for the joystick axis and button conditioner.
`timescale 1ns / 1ps
`default_nettype none

package jac_pkg;

    localparam int SAMPLE_W = 12;
    localparam int AXIS_W   = 8;
    localparam int MAG_W    = 7;
    localparam int MASK_W   = 6;
    localparam int CFG_DW   = 12;
    localparam int CFG_IW   = 3;

    // Event list slots: key i down at bit 2i, key i up at bit 2i+1, joystick last.
    localparam int EV_W       = 11;
    localparam int EV_JOY_BIT = 10;
    localparam logic [EV_W-1:0] EV_UP_MASK = 11'b01010101010;

    localparam logic [CFG_IW-1:0] CFG_X_CENTER      = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_Y_CENTER      = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_AXIS_MODE     = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DEAD_ZONE     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_NAV_THRESHOLD = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_NAV_RELEASE   = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_ADC_PRESENT   = 3'd6;

    localparam logic [SAMPLE_W-1:0] RST_X_CENTER      = 12'd1800;
    localparam logic [SAMPLE_W-1:0] RST_Y_CENTER      = 12'd1680;
    localparam logic [2:0]          RST_AXIS_MODE     = 3'd0;
    localparam logic [MAG_W-1:0]    RST_DEAD_ZONE     = 7'd3;
    localparam logic [MAG_W-1:0]    RST_NAV_THRESHOLD = 7'd20;
    localparam logic [MAG_W-1:0]    RST_NAV_RELEASE   = 7'd10;

    localparam logic [1:0] NAV_NEUTRAL = 2'd0;
    localparam logic [1:0] NAV_POS     = 2'd1;
    localparam logic [1:0] NAV_NEG     = 2'd3;

    typedef enum logic [1:0] {
        KIND_DOWN = 2'd0,
        KIND_UP   = 2'd1,
        KIND_JOY  = 2'd2
    } event_kind_t;

    typedef enum logic [2:0] {
        KEY_WEAPON = 3'd0,
        KEY_MAP    = 3'd1,
        KEY_MENU   = 3'd2,
        KEY_LEFT   = 3'd3,
        KEY_RIGHT  = 3'd4,
        KEY_UP     = 3'd5,
        KEY_DOWN   = 3'd6
    } key_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x_center;
        logic [SAMPLE_W-1:0] y_center;
        logic [2:0]          axis_mode;
        logic [MAG_W-1:0]    dead_zone;
        logic [MAG_W-1:0]    nav_threshold;
        logic [MAG_W-1:0]    nav_release;
        logic                adc_present;
    } cfg_t;

    typedef struct packed {
        logic adc_ok;
        logic fire;
        logic use_btn;
        logic speed;
        logic weapon;
        logic map;
        logic menu;
        logic menu_active;
    } side_t;

    typedef struct packed {
        logic [EV_W-1:0]          ev;
        key_t                     key_x;
        key_t                     key_y;
        logic [MASK_W-1:0]        mask;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
    } ev_list_t;

endpackage

`default_nettype wire

FILE: sv/jac_scale.sv
// Three-stage centering and scaling pipeline for one axis.
`timescale 1ns / 1ps
`default_nettype none

module jac_scale #(
    parameter int ADC_BITS   = 12,
    parameter int AXIS_LIMIT = 65,
    parameter int RAW_SPAN   = 1800
) (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic [jac_pkg::SAMPLE_W-1:0]       raw,
    input  wire logic [jac_pkg::SAMPLE_W-1:0]       center,
    output logic signed [jac_pkg::AXIS_W-1:0]       value
);
    import jac_pkg::*;

    localparam int SW = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] RAW_MASK = SAMPLE_W'((32'd1 << SW) - 32'd1);
    localparam int LW = $clog2(AXIS_LIMIT + 1);
    localparam int PW = SAMPLE_W + LW;
    localparam int MW = PW + 1;
    localparam int QW = PW + 1;
    localparam int DW = $clog2(RAW_SPAN + 1);
    localparam int CW = (PW > DW) ? PW + 1 : DW + 1;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << PW) / RAW_SPAN);
    localparam logic [DW-1:0] SPAN  = DW'(RAW_SPAN);
    localparam logic [LW-1:0] LIMIT = LW'(AXIS_LIMIT);

    logic signed [SAMPLE_W:0] delta;
    logic [SAMPLE_W-1:0]      mag;
    logic [PW-1:0]            prod_next;
    logic [PW-1:0]            prod1_reg;
    logic                     sign1_reg;
    logic [PW+MW-1:0]         full;
    logic [QW-1:0]            q0_next;
    logic [QW-1:0]            q0_reg;
    logic [PW-1:0]            prod2_reg;
    logic                     sign2_reg;
    logic [CW-1:0]            back;
    logic [CW-1:0]            rem;
    logic [QW-1:0]            quot;
    logic [MAG_W-1:0]         mag_next;
    logic [MAG_W-1:0]         mag3_reg;
    logic                     sign3_reg;

    // Stage 1: magnitude of the offset from center, times the axis limit.
    always_comb
    begin
        delta = $signed({1'b0, raw & RAW_MASK}) - $signed({1'b0, center});
        mag = delta[SAMPLE_W] ? SAMPLE_W'(-delta) : SAMPLE_W'(delta);
        prod_next = PW'(mag) * PW'(LIMIT);
    end

    // Stage 2: reciprocal estimate, never above the true quotient and at most one below.
    always_comb
    begin
        full = (PW+MW)'(prod1_reg) * (PW+MW)'(RECIP);
        q0_next = QW'(full >> PW);
    end

    // Stage 3: one correction step, then clamp.
    always_comb
    begin
        back = CW'(q0_reg) * CW'(SPAN);
        rem = CW'(prod2_reg) - back;
        quot = q0_reg + QW'(rem >= CW'(SPAN));
        mag_next = (quot > QW'(AXIS_LIMIT)) ? MAG_W'(AXIS_LIMIT) : MAG_W'(quot);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= prod_next;
            sign1_reg <= delta[SAMPLE_W];
            q0_reg    <= q0_next;
            prod2_reg <= prod1_reg;
            sign2_reg <= sign1_reg;
            mag3_reg  <= mag_next;
            sign3_reg <= sign2_reg;
        end
    end

    assign value = sign3_reg ? -$signed({1'b0, mag3_reg}) : $signed({1'b0, mag3_reg});

endmodule

`default_nettype wire

FILE: sv/jac_events.sv
// Button edges, dead zone, axis mapping, menu navigation and change detection.
`timescale 1ns / 1ps
`default_nettype none

module jac_events (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          take,
    input  wire jac_pkg::side_t                side,
    input  wire logic signed [jac_pkg::AXIS_W-1:0] sx,
    input  wire logic signed [jac_pkg::AXIS_W-1:0] sy,
    input  wire jac_pkg::cfg_t                 cfg,
    output jac_pkg::ev_list_t                  list
);
    import jac_pkg::*;

    typedef struct packed {
        logic       fire;
        logic       neg;
        logic [1:0] latch;
    } nav_t;

    function automatic logic signed [AXIS_W-1:0] dead_zone_apply(
        input logic signed [AXIS_W-1:0] s,
        input logic [MAG_W-1:0]         dz
    );
        logic signed [AXIS_W:0] s9;
        logic signed [AXIS_W:0] dz9;
        s9 = {s[AXIS_W-1], s};
        dz9 = $signed({2'b00, dz});
        dead_zone_apply = (s9 > -dz9 && s9 < dz9) ? '0 : s;
    endfunction

    function automatic nav_t nav_step(
        input logic signed [AXIS_W-1:0] v,
        input logic [1:0]               latch,
        input logic [MAG_W-1:0]         th,
        input logic [MAG_W-1:0]         rl
    );
        logic signed [AXIS_W:0] v9;
        logic signed [AXIS_W:0] th9;
        logic signed [AXIS_W:0] rl9;
        logic                   dneg;
        logic                   dpos;
        nav_t                   r;
        v9 = {v[AXIS_W-1], v};
        th9 = $signed({2'b00, th});
        rl9 = $signed({2'b00, rl});
        dneg = (v9 <= -th9);
        dpos = !dneg && (v9 >= th9);
        r.fire = 1'b0;
        r.neg = dneg;
        r.latch = latch;
        if ((dneg || dpos) && latch == NAV_NEUTRAL)
        begin
            r.fire = 1'b1;
            r.latch = dneg ? NAV_NEG : NAV_POS;
        end
        else if (latch != NAV_NEUTRAL && v9 > -rl9 && v9 < rl9)
        begin
            r.latch = NAV_NEUTRAL;
        end
        nav_step = r;
    endfunction

    logic                     weapon_seen_reg;
    logic                     map_seen_reg;
    logic                     menu_seen_reg;
    logic [1:0]               nav_x_reg;
    logic [1:0]               nav_y_reg;
    logic [MASK_W-1:0]        sent_mask_reg;
    logic signed [AXIS_W-1:0] sent_x_reg;
    logic signed [AXIS_W-1:0] sent_y_reg;

    logic [1:0]               nav_x_next;
    logic [1:0]               nav_y_next;
    logic [MASK_W-1:0]        sent_mask_next;
    logic signed [AXIS_W-1:0] sent_x_next;
    logic signed [AXIS_W-1:0] sent_y_next;

    logic                     analog;
    logic                     w_edge;
    logic                     m_edge;
    logic                     mn_edge;
    logic [MASK_W-1:0]        mask;
    logic signed [AXIS_W-1:0] cx;
    logic signed [AXIS_W-1:0] cy;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] jx;
    logic signed [AXIS_W-1:0] jy;
    nav_t                     nx;
    nav_t                     ny;
    logic                     x_pulse;
    logic                     y_pulse;
    logic                     joy;

    always_comb
    begin
        w_edge  = side.weapon & ~weapon_seen_reg;
        m_edge  = side.map & ~map_seen_reg;
        mn_edge = side.menu & ~menu_seen_reg;
        analog  = cfg.adc_present & side.adc_ok;
        mask = {side.fire, 1'b0, side.use_btn, side.speed, 2'b00};

        cx = dead_zone_apply(sx, cfg.dead_zone);
        cy = dead_zone_apply(sy, cfg.dead_zone);
        ax = cfg.axis_mode[0] ? cy : cx;
        ay = cfg.axis_mode[0] ? cx : cy;
        if (cfg.axis_mode[1])
        begin
            ax = -ax;
        end
        if (cfg.axis_mode[2])
        begin
            ay = -ay;
        end

        nx = nav_step(ax, nav_x_reg, cfg.nav_threshold, cfg.nav_release);
        ny = nav_step(ay, nav_y_reg, cfg.nav_threshold, cfg.nav_release);

        x_pulse = 1'b0;
        y_pulse = 1'b0;
        jx = ax;
        jy = ay;
        nav_x_next = nav_x_reg;
        nav_y_next = nav_y_reg;
        if (analog)
        begin
            if (side.menu_active)
            begin
                x_pulse = nx.fire;
                y_pulse = ny.fire;
                nav_x_next = nx.latch;
                nav_y_next = ny.latch;
                jx = '0;
                jy = '0;
            end
            else
            begin
                nav_x_next = NAV_NEUTRAL;
                nav_y_next = NAV_NEUTRAL;
            end
        end

        joy = analog && (mask != sent_mask_reg || jx != sent_x_reg || jy != sent_y_reg);
        sent_mask_next = joy ? mask : sent_mask_reg;
        sent_x_next    = joy ? jx : sent_x_reg;
        sent_y_next    = joy ? jy : sent_y_reg;

        list.ev = {joy, y_pulse, y_pulse, x_pulse, x_pulse,
                   mn_edge, mn_edge, m_edge, m_edge, w_edge, w_edge};
        list.key_x = nx.neg ? KEY_LEFT : KEY_RIGHT;
        list.key_y = ny.neg ? KEY_UP : KEY_DOWN;
        list.mask = mask;
        list.ax = jx;
        list.ay = jy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weapon_seen_reg <= 1'b0;
            map_seen_reg    <= 1'b0;
            menu_seen_reg   <= 1'b0;
            nav_x_reg       <= NAV_NEUTRAL;
            nav_y_reg       <= NAV_NEUTRAL;
            sent_mask_reg   <= '0;
            sent_x_reg      <= '0;
            sent_y_reg      <= '0;
        end
        else if (take)
        begin
            weapon_seen_reg <= side.weapon;
            map_seen_reg    <= side.map;
            menu_seen_reg   <= side.menu;
            nav_x_reg       <= nav_x_next;
            nav_y_reg       <= nav_y_next;
            sent_mask_reg   <= sent_mask_next;
            sent_x_reg      <= sent_x_next;
            sent_y_reg      <= sent_y_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/jac_serial.sv
// Holds one item's event list and sends its events out one request per cycle while out_stall is low.
`timescale 1ns / 1ps
`default_nettype none

module jac_serial (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire jac_pkg::ev_list_t             list,
    input  wire logic                          out_stall,
    output logic                               list_free,
    output logic                               out_valid,
    output logic [1:0]                         event_kind,
    output logic [2:0]                         key_code,
    output logic [jac_pkg::MASK_W-1:0]         button_mask,
    output logic signed [jac_pkg::AXIS_W-1:0]  axis_x,
    output logic signed [jac_pkg::AXIS_W-1:0]  axis_y,
    output logic                               last_of_run
);
    import jac_pkg::*;

    logic [EV_W-1:0]          pend_reg;
    logic [EV_W-1:0]          pend_next;
    ev_list_t                 hold_reg;
    logic [EV_W-1:0]          pick;
    logic [EV_W-1:0]          after;
    logic                     pop;
    logic                     out_valid_reg;
    event_kind_t              kind_reg;
    key_t                     key_reg;
    logic [MASK_W-1:0]        mask_reg;
    logic signed [AXIS_W-1:0] ax_reg;
    logic signed [AXIS_W-1:0] ay_reg;
    logic                     last_reg;
    event_kind_t              kind_next;
    key_t                     key_next;

    always_comb
    begin
        pop = (pend_reg != '0) && (!out_valid_reg || !out_stall);
        pick = pend_reg & (~pend_reg + EV_W'(1));
        after = pop ? (pend_reg & ~pick) : pend_reg;
        list_free = (after == '0);
        pend_next = load ? list.ev : after;

        if (pick[EV_JOY_BIT])
        begin
            kind_next = KIND_JOY;
        end
        else if ((pick & EV_UP_MASK) != '0)
        begin
            kind_next = KIND_UP;
        end
        else
        begin
            kind_next = KIND_DOWN;
        end

        if (pick[1] | pick[0])
        begin
            key_next = KEY_WEAPON;
        end
        else if (pick[3] | pick[2])
        begin
            key_next = KEY_MAP;
        end
        else if (pick[5] | pick[4])
        begin
            key_next = KEY_MENU;
        end
        else if (pick[7] | pick[6])
        begin
            key_next = hold_reg.key_x;
        end
        else if (pick[9] | pick[8])
        begin
            key_next = hold_reg.key_y;
        end
        else
        begin
            key_next = KEY_WEAPON;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= list;
        end
        if (pop)
        begin
            kind_reg <= kind_next;
            key_reg  <= key_next;
            last_reg <= (after == '0);
            if (pick[EV_JOY_BIT])
            begin
                mask_reg <= hold_reg.mask;
                ax_reg   <= hold_reg.ax;
                ay_reg   <= hold_reg.ay;
            end
            else
            begin
                mask_reg <= '0;
                ax_reg   <= '0;
                ay_reg   <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = kind_reg;
    assign key_code    = key_reg;
    assign button_mask = mask_reg;
    assign axis_x      = ax_reg;
    assign axis_y      = ay_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

FILE: sv/joystick_axis_and_button_conditioner.sv
// Top level of the joystick axis and button conditioner.
//
//  channel   direction  handshake            payload
//  poll      in         in_valid / in_stall  raw_x raw_y adc_ok button levels menu_active
//  event     out        out_valid/out_stall  event_kind key_code button_mask axis_x
//                                            axis_y last_of_run
//  config    in         cfg_we               cfg_index cfg_data
//
// A poll request passes an input register and three scaling stages; its event list is
// then loaded into the serializer, which moves its first event into the output register. The
// event serializer sends one event per cycle while out_stall is low; a poll causes up to
// eleven events. Reset restores the register defaults and clears edge, latch and sent state.
// in_stall is high while a request waits in the last stage and the serializer still holds
// events of an earlier request beyond the one being sent; out_stall holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module joystick_axis_and_button_conditioner #(
    parameter int ADC_BITS   = 12,
    parameter int AXIS_LIMIT = 65,
    parameter int RAW_SPAN   = 1800
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [jac_pkg::SAMPLE_W-1:0]       raw_x,
    input  wire logic [jac_pkg::SAMPLE_W-1:0]       raw_y,
    input  wire logic                               adc_ok,
    input  wire logic                               fire_btn,
    input  wire logic                               btn_use,
    input  wire logic                               speed_btn,
    input  wire logic                               weapon_btn,
    input  wire logic                               btn_map,
    input  wire logic                               menu_btn,
    input  wire logic                               menu_active,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              event_kind,
    output logic [2:0]                              key_code,
    output logic [jac_pkg::MASK_W-1:0]              button_mask,
    output logic signed [jac_pkg::AXIS_W-1:0]       axis_x,
    output logic signed [jac_pkg::AXIS_W-1:0]       axis_y,
    output logic                                    last_of_run,
    input  wire logic                               cfg_we,
    input  wire logic [jac_pkg::CFG_IW-1:0]         cfg_index,
    input  wire logic [jac_pkg::CFG_DW-1:0]         cfg_data
);
    import jac_pkg::*;

    cfg_t                     cfg_reg;
    logic [3:0]               valid_reg;
    side_t                    side_reg [4];
    logic [SAMPLE_W-1:0]      raw_x_reg;
    logic [SAMPLE_W-1:0]      raw_y_reg;
    side_t                    side_in;
    logic                     en;
    logic                     take;
    logic                     list_free;
    logic signed [AXIS_W-1:0] sx;
    logic signed [AXIS_W-1:0] sy;
    ev_list_t                 list;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_center      <= RST_X_CENTER;
            cfg_reg.y_center      <= RST_Y_CENTER;
            cfg_reg.axis_mode     <= RST_AXIS_MODE;
            cfg_reg.dead_zone     <= RST_DEAD_ZONE;
            cfg_reg.nav_threshold <= RST_NAV_THRESHOLD;
            cfg_reg.nav_release   <= RST_NAV_RELEASE;
            cfg_reg.adc_present   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_X_CENTER:      cfg_reg.x_center      <= cfg_data;
                CFG_Y_CENTER:      cfg_reg.y_center      <= cfg_data;
                CFG_AXIS_MODE:     cfg_reg.axis_mode     <= cfg_data[2:0];
                CFG_DEAD_ZONE:     cfg_reg.dead_zone     <= cfg_data[MAG_W-1:0];
                CFG_NAV_THRESHOLD: cfg_reg.nav_threshold <= cfg_data[MAG_W-1:0];
                CFG_NAV_RELEASE:   cfg_reg.nav_release   <= cfg_data[MAG_W-1:0];
                CFG_ADC_PRESENT:   cfg_reg.adc_present   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // The whole pipeline moves together; it only holds when the last stage
    // cannot hand its event list to the serializer.
    assign en       = !valid_reg[3] || list_free;
    assign take     = valid_reg[3] && en;
    assign in_stall = !en;

    always_comb
    begin
        side_in.adc_ok      = adc_ok;
        side_in.fire        = fire_btn;
        side_in.use_btn     = btn_use;
        side_in.speed       = speed_btn;
        side_in.weapon      = weapon_btn;
        side_in.map         = btn_map;
        side_in.menu        = menu_btn;
        side_in.menu_active = menu_active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_x_reg   <= raw_x;
            raw_y_reg   <= raw_y;
            side_reg[0] <= side_in;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
            side_reg[3] <= side_reg[2];
        end
    end

    jac_scale #(
        .ADC_BITS   (ADC_BITS),
        .AXIS_LIMIT (AXIS_LIMIT),
        .RAW_SPAN   (RAW_SPAN)
    ) u_scale_x (
        .clk    (clk),
        .en     (en),
        .raw    (raw_x_reg),
        .center (cfg_reg.x_center),
        .value  (sx)
    );

    jac_scale #(
        .ADC_BITS   (ADC_BITS),
        .AXIS_LIMIT (AXIS_LIMIT),
        .RAW_SPAN   (RAW_SPAN)
    ) u_scale_y (
        .clk    (clk),
        .en     (en),
        .raw    (raw_y_reg),
        .center (cfg_reg.y_center),
        .value  (sy)
    );

    jac_events u_events (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .side  (side_reg[3]),
        .sx    (sx),
        .sy    (sy),
        .cfg   (cfg_reg),
        .list  (list)
    );

    jac_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take),
        .list        (list),
        .out_stall   (out_stall),
        .list_free   (list_free),
        .out_valid   (out_valid),
        .event_kind  (event_kind),
        .key_code    (key_code),
        .button_mask (button_mask),
        .axis_x      (axis_x),
        .axis_y      (axis_y),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the joystick axis and button conditioner.
`timescale 1ns / 1ps

module testbench;
    import jac_pkg::*;

    localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd7;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 1500;
    localparam int AXIS_MAX        = 65;
    localparam int SPAN            = 1800;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE
    } stall_mode_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw_x;
        logic [SAMPLE_W-1:0] raw_y;
        side_t               side;
    } poll_t;

    typedef struct packed {
        event_kind_t              kind;
        key_t                     key;
        logic [MASK_W-1:0]        mask;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic                     last;
    } joy_event_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [SAMPLE_W-1:0]        raw_x;
    logic [SAMPLE_W-1:0]        raw_y;
    logic                       adc_ok;
    logic                       fire_btn;
    logic                       btn_use;
    logic                       speed_btn;
    logic                       weapon_btn;
    logic                       btn_map;
    logic                       menu_btn;
    logic                       menu_active;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [1:0]                 event_kind;
    logic [2:0]                 key_code;
    logic [MASK_W-1:0]          button_mask;
    logic signed [AXIS_W-1:0]   axis_x;
    logic signed [AXIS_W-1:0]   axis_y;
    logic                       last_of_run;
    logic                       cfg_we;
    logic [CFG_IW-1:0]          cfg_index;
    logic [CFG_DW-1:0]          cfg_data;

    // Predictor copy of the registers and of the block's edge, latch and sent state.
    cfg_t                       cfg_model;
    logic                       weapon_prev;
    logic                       map_prev;
    logic                       menu_prev;
    int                         nav_x_dir;
    int                         nav_y_dir;
    logic [MASK_W-1:0]          sent_mask_model;
    int                         sent_x_model;
    int                         sent_y_model;

    joy_event_t                 pending_events[$];
    joy_event_t                 run_events[$];
    joy_event_t                 head;
    poll_t                      last_poll;
    int                         errors = 0;
    int                         burst_left = 0;
    int                         idle_cycles = 0;

    stall_mode_t                recv_mode = STALL_NONE;
    int                         recv_left = 0;
    int                         hold_count = 0;
    bit                         hold_request = 1'b0;

    joystick_axis_and_button_conditioner u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .raw_x       (raw_x),
        .raw_y       (raw_y),
        .adc_ok      (adc_ok),
        .fire_btn    (fire_btn),
        .btn_use     (btn_use),
        .speed_btn   (speed_btn),
        .weapon_btn  (weapon_btn),
        .btn_map     (btn_map),
        .menu_btn    (menu_btn),
        .menu_active (menu_active),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .key_code    (key_code),
        .button_mask (button_mask),
        .axis_x      (axis_x),
        .axis_y      (axis_y),
        .last_of_run (last_of_run),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void add_event(event_kind_t kind, key_t key, logic [MASK_W-1:0] mask,
                                      int ax, int ay);
        joy_event_t e;
        e.kind = kind;
        e.key  = key;
        e.mask = mask;
        e.ax   = ax[AXIS_W-1:0];
        e.ay   = ay[AXIS_W-1:0];
        e.last = 1'b0;
        run_events.push_back(e);
    endfunction

    function automatic void add_pulse(key_t key);
        add_event(KIND_DOWN, key, '0, 0, 0);
        add_event(KIND_UP, key, '0, 0, 0);
    endfunction

    function automatic int axis_value(logic [SAMPLE_W-1:0] raw, logic [SAMPLE_W-1:0] center);
        int delta;
        int s;
        int dz;
        delta = int'(raw) - int'(center);
        s = (delta * AXIS_MAX) / SPAN;
        dz = int'(cfg_model.dead_zone);
        if (s > AXIS_MAX)
            s = AXIS_MAX;
        else if (s < -AXIS_MAX)
            s = -AXIS_MAX;
        if (s > -dz && s < dz)
            s = 0;
        return s;
    endfunction

    // Returns the updated direction latch; a pulse fires only from neutral.
    function automatic int nav_step(int v, int latch, key_t key_neg, key_t key_pos);
        int th;
        int rl;
        int dir;
        th = int'(cfg_model.nav_threshold);
        rl = int'(cfg_model.nav_release);
        dir = 0;
        if (v <= -th)
            dir = -1;
        else if (v >= th)
            dir = 1;
        if (dir != 0 && latch == 0)
        begin
            add_pulse(dir < 0 ? key_neg : key_pos);
            latch = dir;
        end
        else if (latch != 0 && v > -rl && v < rl)
        begin
            latch = 0;
        end
        return latch;
    endfunction

    function automatic void predict_poll(poll_t p);
        logic [MASK_W-1:0] mask;
        int                sx;
        int                sy;
        int                ax;
        int                ay;
        int                i;
        joy_event_t        tail;
        run_events.delete();
        if (p.side.weapon && !weapon_prev)
            add_pulse(KEY_WEAPON);
        weapon_prev = p.side.weapon;
        if (p.side.map && !map_prev)
            add_pulse(KEY_MAP);
        map_prev = p.side.map;
        if (p.side.menu && !menu_prev)
            add_pulse(KEY_MENU);
        menu_prev = p.side.menu;

        if (cfg_model.adc_present && p.side.adc_ok)
        begin
            mask = {p.side.fire, 1'b0, p.side.use_btn, p.side.speed, 2'b00};
            sx = axis_value(p.raw_x, cfg_model.x_center);
            sy = axis_value(p.raw_y, cfg_model.y_center);
            ax = cfg_model.axis_mode[0] ? sy : sx;
            ay = cfg_model.axis_mode[0] ? sx : sy;
            if (cfg_model.axis_mode[1])
                ax = -ax;
            if (cfg_model.axis_mode[2])
                ay = -ay;
            if (p.side.menu_active)
            begin
                nav_x_dir = nav_step(ax, nav_x_dir, KEY_LEFT, KEY_RIGHT);
                nav_y_dir = nav_step(ay, nav_y_dir, KEY_UP, KEY_DOWN);
                ax = 0;
                ay = 0;
            end
            else
            begin
                nav_x_dir = 0;
                nav_y_dir = 0;
            end
            if (mask != sent_mask_model || ax != sent_x_model || ay != sent_y_model)
            begin
                add_event(KIND_JOY, KEY_WEAPON, mask, ax, ay);
                sent_mask_model = mask;
                sent_x_model = ax;
                sent_y_model = ay;
            end
        end

        if (run_events.size() > 0)
        begin
            tail = run_events.pop_back();
            tail.last = 1'b1;
            run_events.push_back(tail);
        end
        for (i = 0; i < run_events.size(); i++)
            pending_events.push_back(run_events[i]);
    endfunction

    function automatic void reset_model();
        cfg_model.x_center      = RST_X_CENTER;
        cfg_model.y_center      = RST_Y_CENTER;
        cfg_model.axis_mode     = RST_AXIS_MODE;
        cfg_model.dead_zone     = RST_DEAD_ZONE;
        cfg_model.nav_threshold = RST_NAV_THRESHOLD;
        cfg_model.nav_release   = RST_NAV_RELEASE;
        cfg_model.adc_present   = 1'b0;
        weapon_prev = 1'b0;
        map_prev = 1'b0;
        menu_prev = 1'b0;
        nav_x_dir = 0;
        nav_y_dir = 0;
        sent_mask_model = '0;
        sent_x_model = 0;
        sent_y_model = 0;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic poll_t make_poll(int rx, int ry, bit ok, bit fire, bit use_b, bit speed,
                                        bit weapon, bit map, bit menu, bit menu_on);
        poll_t p;
        p.raw_x = rx[SAMPLE_W-1:0];
        p.raw_y = ry[SAMPLE_W-1:0];
        p.side.adc_ok = ok;
        p.side.fire = fire;
        p.side.use_btn = use_b;
        p.side.speed = speed;
        p.side.weapon = weapon;
        p.side.map = map;
        p.side.menu = menu;
        p.side.menu_active = menu_on;
        return p;
    endfunction

    // Half of the samples lie around the rest point so the dead zone and hysteresis are exercised.
    function automatic logic [SAMPLE_W-1:0] random_raw(logic [SAMPLE_W-1:0] center);
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            v = int'(center) + int'($urandom_range(0, 2000)) - 1000;
        else if (pick < 8)
            v = $urandom_range(0, 4095);
        else if (pick == 8)
            v = 0;
        else
            v = 4095;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic poll_t random_poll(poll_t prev);
        poll_t p;
        p = prev;
        p.raw_x = random_raw(cfg_model.x_center);
        p.raw_y = random_raw(cfg_model.y_center);
        p.side.adc_ok = ($urandom_range(0, 9) != 0);
        p.side.fire    = prev.side.fire    ^ ($urandom_range(0, 3) == 0);
        p.side.use_btn = prev.side.use_btn ^ ($urandom_range(0, 3) == 0);
        p.side.speed   = prev.side.speed   ^ ($urandom_range(0, 3) == 0);
        p.side.weapon  = prev.side.weapon  ^ ($urandom_range(0, 3) == 0);
        p.side.map     = prev.side.map     ^ ($urandom_range(0, 3) == 0);
        p.side.menu    = prev.side.menu    ^ ($urandom_range(0, 3) == 0);
        p.side.menu_active = prev.side.menu_active ^ ($urandom_range(0, 9) == 0);
        return p;
    endfunction

    // Called at a rising edge; returns after the request is taken and any idle gap that follows.
    task automatic send_poll(poll_t p);
        raw_x <= p.raw_x;
        raw_y <= p.raw_y;
        adc_ok <= p.side.adc_ok;
        fire_btn <= p.side.fire;
        btn_use <= p.side.use_btn;
        speed_btn <= p.side.speed;
        weapon_btn <= p.side.weapon;
        btn_map <= p.side.map;
        menu_btn <= p.side.menu;
        menu_active <= p.side.menu_active;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_poll(p);
        last_poll = p;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // Waits until every expected event has arrived and the pipeline has emptied.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data, bit last);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_X_CENTER:      cfg_model.x_center = data;
            CFG_Y_CENTER:      cfg_model.y_center = data;
            CFG_AXIS_MODE:     cfg_model.axis_mode = data[2:0];
            CFG_DEAD_ZONE:     cfg_model.dead_zone = data[MAG_W-1:0];
            CFG_NAV_THRESHOLD: cfg_model.nav_threshold = data[MAG_W-1:0];
            CFG_NAV_RELEASE:   cfg_model.nav_release = data[MAG_W-1:0];
            CFG_ADC_PRESENT:   cfg_model.adc_present = data[0];
            default:           ;
        endcase
        if (last)
            cfg_we <= 1'b0;
    endtask

    // Narrow registers get random upper data bits, which the block must ignore.
    task automatic apply_config(logic [11:0] xc, logic [11:0] yc, logic [2:0] mode,
                                logic [6:0] dz, logic [6:0] th, logic [6:0] rl,
                                logic present);
        logic [CFG_DW-1:0] junk;
        junk = $urandom;
        write_reg(CFG_X_CENTER, xc, 1'b0);
        write_reg(CFG_Y_CENTER, yc, 1'b0);
        write_reg(CFG_AXIS_MODE, {junk[8:0], mode}, 1'b0);
        junk = $urandom;
        write_reg(CFG_DEAD_ZONE, {junk[4:0], dz}, 1'b0);
        junk = $urandom;
        write_reg(CFG_NAV_THRESHOLD, {junk[4:0], th}, 1'b0);
        junk = $urandom;
        write_reg(CFG_NAV_RELEASE, {junk[4:0], rl}, 1'b0);
        junk = $urandom;
        write_reg(CFG_ADC_PRESENT, {junk[10:0], present}, 1'b0);
        junk = $urandom;
        write_reg(CFG_UNUSED, junk, 1'b1);
    endtask

    task automatic run_random_items(int count, bit hold_off);
        poll_t p;
        int    i;
        p = last_poll;
        for (i = 0; i < count; i++)
        begin
            if (hold_off && i == 4)
                hold_request = 1'b1;
            p = random_poll(p);
            send_poll(p);
        end
        drain_block();
    endtask

    // ---------------------------------------------------------------- tests

    // Analog axes are absent after reset, so only key pulses come out.
    task automatic test_button_edges();
        send_poll(make_poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(4095, 4095, 1, 1, 1, 1, 1, 1, 1, 1));
        send_poll(make_poll(4095, 4095, 1, 1, 1, 1, 1, 1, 1, 1));
        send_poll(make_poll(2048, 2048, 1, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(1234, 567, 0, 0, 0, 0, 0, 1, 0, 0));
        send_poll(make_poll(0, 4095, 1, 0, 0, 0, 1, 0, 1, 1));
        drain_block();
    endtask

    // Uses the reset centers and dead zone; covers clamping, truncation and the
    // dead zone boundary on both sides, a failed read and the button mask.
    task automatic test_axis_scaling();
        write_reg(CFG_ADC_PRESENT, 12'h001, 1'b1);
        send_poll(make_poll(0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(4095, 4095, 1, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(4095, 4095, 1, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(1800, 1680, 1, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(1884, 1596, 1, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(1883, 1597, 1, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(0, 4095, 0, 1, 1, 1, 0, 0, 0, 0));
        send_poll(make_poll(1800, 1680, 1, 1, 0, 1, 0, 0, 0, 0));
        send_poll(make_poll(1800, 1680, 1, 1, 1, 1, 0, 0, 0, 0));
        drain_block();
    endtask

    // Threshold and release hysteresis in menu mode, leaving the menu, and one poll
    // that causes the largest number of events.
    task automatic test_menu_navigation();
        send_poll(make_poll(4095, 1680, 1, 0, 0, 0, 0, 0, 0, 1));
        send_poll(make_poll(2216, 1680, 1, 0, 0, 0, 0, 0, 0, 1));
        send_poll(make_poll(1938, 1680, 1, 0, 0, 0, 0, 0, 0, 1));
        send_poll(make_poll(0, 0, 1, 0, 0, 0, 0, 0, 0, 1));
        send_poll(make_poll(1800, 4095, 1, 0, 0, 0, 0, 0, 0, 1));
        send_poll(make_poll(1800, 1680, 1, 0, 0, 0, 0, 0, 0, 1));
        send_poll(make_poll(1800, 4095, 1, 0, 0, 0, 0, 0, 0, 1));
        send_poll(make_poll(4095, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(4095, 0, 1, 1, 1, 1, 1, 1, 1, 1));
        send_poll(make_poll(4095, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        drain_block();
    endtask

    // Register extremes, including values beyond the axis limit.
    task automatic test_config_extremes();
        apply_config(12'd0, 12'd0, 3'd7, 7'd0, 7'd0, 7'd0, 1'b1);
        run_random_items(38, 1'b0);
        apply_config(12'd4095, 12'd4095, 3'd6, 7'd65, 7'd65, 7'd65, 1'b1);
        run_random_items(38, 1'b0);
        apply_config(12'd2048, 12'd1024, 3'd5, 7'd0, 7'd1, 7'd127, 1'b1);
        run_random_items(38, 1'b0);
        apply_config(12'd1800, 12'd1680, 3'd3, 7'd127, 7'd0, 7'd0, 1'b1);
        run_random_items(38, 1'b0);
    endtask

    // Random settings; the first phase also holds the receiver off for a long stretch.
    task automatic test_random_configs();
        logic [2:0] modes [4];
        int         ph;
        modes[0] = 3'd0;
        modes[1] = 3'd1;
        modes[2] = 3'd4;
        modes[3] = 3'($urandom_range(0, 7));
        for (ph = 0; ph < 4; ph++)
        begin
            apply_config(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                         modes[ph], 7'($urandom_range(0, 12)), 7'($urandom_range(0, 40)),
                         7'($urandom_range(0, 30)), ph != 1);
            run_random_items(38, ph == 0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        raw_x = '0;
        raw_y = '0;
        adc_ok = 1'b0;
        fire_btn = 1'b0;
        btn_use = 1'b0;
        speed_btn = 1'b0;
        weapon_btn = 1'b0;
        btn_map = 1'b0;
        menu_btn = 1'b0;
        menu_active = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        reset_model();
        last_poll = make_poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_button_edges();
        test_axis_scaling();
        test_menu_navigation();
        test_config_extremes();
        test_random_configs();

        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------- receiver and checks

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_count = HOLD_OFF_CYCLES;
        end
        if (hold_count > 0)
        begin
            hold_count--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (recv_left == 0)
            begin
                recv_mode = stall_mode_t'($urandom_range(0, 3));
                recv_left = $urandom_range(5, 60);
            end
            else
            begin
                recv_left--;
            end
            case (recv_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= recv_left[0];
            endcase
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: event with none expected, expected nothing, actual kind %0d key %0d",
                         $time, event_kind, key_code);
                errors++;
            end
            else
            begin
                head = pending_events.pop_front();
                check_field("event_kind", head.kind, event_kind);
                check_field("key_code", head.key, key_code);
                check_field("button_mask", head.mask, button_mask);
                check_field("axis_x", head.ax, axis_x);
                check_field("axis_y", head.ay, axis_y);
                check_field("last_of_run", head.last, last_of_run);
            end
        end
    end

    // Ends the run when neither channel nor the register port moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

endmodule

FILE: joystick_axis_and_button_conditioner.f
sv/jac_pkg.sv
sv/jac_scale.sv
sv/jac_events.sv
sv/jac_serial.sv
sv/joystick_axis_and_button_conditioner.sv
test/testbench.sv
